// ----- design/lcdnib_pkg.sv -----
// lcdnib_pkg: shared types, codes and tables for the lcd nibble interface sequencer
// used by lcdnib_ctrl, lcdnib_dp and lcd_nibble_interface_sequencer; depends on nothing
package lcdnib_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int COL_W    = 6;
   localparam int NIB_W    = 4;
   localparam int WAIT_W   = 14;
   localparam int PHASE_W  = 3;
   localparam int IDX_W    = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSTR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DATA  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GOTO  = 3'd4;

   // hold times in microseconds
   localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 14'd15000;
   localparam logic [WAIT_W-1:0] WAIT_STROBE   = 14'd1;

   // byte send phases
   localparam logic [PHASE_W-1:0] PH_SETUP = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HI_EN = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HI    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LO_EN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LO    = 3'd4;

   // index of the final set-up byte
   localparam logic [IDX_W-1:0] IDX_LAST = 3'd6;

   // fixed bytes
   localparam logic [BYTE_W-1:0] BYTE_CLEAR = 8'h01;

   // set-up byte table of the init sequence
   function automatic logic [BYTE_W-1:0] setup_byte(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h33;
         3'd2:    b = 8'h32;
         3'd3:    b = 8'h28;
         3'd4:    b = 8'h08;
         3'd5:    b = 8'h0F;
         3'd6:    b = 8'h01;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture the accepted word
      logic emit_power; // emit the power-up wait state
      logic emit_phase; // emit the current byte phase and advance
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;   // output register can take a new state
      logic seq_done;   // current phase is the final state of the command
   } dp_status_type;

endpackage

// ----- design/lcdnib_dp.sv -----
// lcdnib_dp: byte, phase and set-up index registers plus the registered output state
// depends on lcdnib_pkg
module lcdnib_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  lcdnib_pkg::dp_cmd_type             cmd,
   output lcdnib_pkg::dp_status_type          status,
   input  logic [lcdnib_pkg::CMD_W-1:0]       in_command,
   input  logic [lcdnib_pkg::BYTE_W-1:0]      in_value,
   input  logic [lcdnib_pkg::COL_W-1:0]       in_column,
   input  logic                               in_row,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_reg_select,
   output logic                               out_enable,
   output logic [lcdnib_pkg::NIB_W-1:0]       out_nibble,
   output logic [lcdnib_pkg::WAIT_W-1:0]      out_wait_us,
   output logic                               out_last
);

   logic [lcdnib_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                           rs_ff, rs_in;
   logic                           init_ff, init_in;
   logic [lcdnib_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [lcdnib_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic                           o_rs_ff, o_rs_in;
   logic                           o_en_ff, o_en_in;
   logic [lcdnib_pkg::NIB_W-1:0]   o_nib_ff, o_nib_in;
   logic [lcdnib_pkg::WAIT_W-1:0]  o_wait_ff, o_wait_in;
   logic                           o_last_ff, o_last_in;

   logic [lcdnib_pkg::BYTE_W-1:0]  cur_byte;
   logic [lcdnib_pkg::BYTE_W-1:0]  load_byte;
   logic [lcdnib_pkg::NIB_W-1:0]   hi_nib;
   logic [lcdnib_pkg::NIB_W-1:0]   lo_nib;
   logic                           phase_end;
   logic                           seq_end;

   // byte to send for the accepted word
   always_comb begin
      case (in_command)
         lcdnib_pkg::CMD_INSTR: load_byte = in_value;
         lcdnib_pkg::CMD_DATA:  load_byte = in_value;
         lcdnib_pkg::CMD_CLEAR: load_byte = lcdnib_pkg::BYTE_CLEAR;
         lcdnib_pkg::CMD_GOTO:  load_byte = {1'b1, in_row, in_column};
         default:               load_byte = '0;
      endcase
   end

   // current byte: table entry during init, captured byte otherwise
   assign cur_byte  = init_ff ? lcdnib_pkg::setup_byte(idx_ff) : byte_ff;
   assign hi_nib    = cur_byte[7:4];
   assign lo_nib    = cur_byte[3:0];
   assign phase_end = (phase_ff == lcdnib_pkg::PH_LO);
   assign seq_end   = phase_end && (!init_ff || idx_ff == lcdnib_pkg::IDX_LAST);

   // status to the controller
   assign status.out_free = !valid_ff || out_ready;
   assign status.seq_done = seq_end;

   // sequence registers
   always_comb begin
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      init_in  = init_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         byte_in  = load_byte;
         rs_in    = (in_command == lcdnib_pkg::CMD_DATA);
         init_in  = (in_command == lcdnib_pkg::CMD_INIT);
         phase_in = lcdnib_pkg::PH_SETUP;
         idx_in   = '0;
      end else if (cmd.emit_phase) begin
         if (phase_end) begin
            phase_in = lcdnib_pkg::PH_SETUP;
            idx_in   = idx_ff + 1'b1;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   // next output state
   always_comb begin
      valid_in  = valid_ff;
      o_rs_in   = o_rs_ff;
      o_en_in   = o_en_ff;
      o_nib_in  = o_nib_ff;
      o_wait_in = o_wait_ff;
      o_last_in = o_last_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.emit_power) begin
         valid_in  = 1'b1;
         o_rs_in   = 1'b0;
         o_en_in   = 1'b0;
         o_nib_in  = '0;
         o_wait_in = lcdnib_pkg::WAIT_POWER_UP;
         o_last_in = 1'b0;
      end else if (cmd.emit_phase) begin
         valid_in  = 1'b1;
         o_rs_in   = rs_ff;
         o_wait_in = lcdnib_pkg::WAIT_STROBE;
         o_last_in = seq_end;
         case (phase_ff)
            lcdnib_pkg::PH_SETUP: begin
               o_en_in  = 1'b0;
               o_nib_in = '0;
            end
            lcdnib_pkg::PH_HI_EN: begin
               o_en_in  = 1'b1;
               o_nib_in = hi_nib;
            end
            lcdnib_pkg::PH_HI: begin
               o_en_in  = 1'b0;
               o_nib_in = hi_nib;
            end
            lcdnib_pkg::PH_LO_EN: begin
               o_en_in  = 1'b1;
               o_nib_in = lo_nib;
            end
            default: begin
               o_en_in  = 1'b0;
               o_nib_in = lo_nib;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         init_ff  <= 1'b0;
         phase_ff <= lcdnib_pkg::PH_SETUP;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         init_ff  <= init_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      rs_ff     <= rs_in;
      o_rs_ff   <= o_rs_in;
      o_en_ff   <= o_en_in;
      o_nib_ff  <= o_nib_in;
      o_wait_ff <= o_wait_in;
      o_last_ff <= o_last_in;
   end

   assign out_valid      = valid_ff;
   assign out_reg_select = o_rs_ff;
   assign out_enable     = o_en_ff;
   assign out_nibble     = o_nib_ff;
   assign out_wait_us    = o_wait_ff;
   assign out_last       = o_last_ff;

endmodule

// ----- design/lcdnib_ctrl.sv -----
// lcdnib_ctrl: one-hot state machine that accepts a word and steps the datapath
// depends on lcdnib_pkg
module lcdnib_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lcdnib_pkg::CMD_W-1:0]  in_command,
   input  lcdnib_pkg::dp_status_type     status,
   output lcdnib_pkg::dp_cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_POWER = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      cmd_known;

   // codes above goto carry no work
   assign cmd_known = (in_command <= lcdnib_pkg::CMD_GOTO);
   assign in_ready  = (state_ff == ST_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.emit_power = 1'b0;
      cmd.emit_phase = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid && cmd_known) begin
               cmd.load = 1'b1;
               state_in = (in_command == lcdnib_pkg::CMD_INIT) ? ST_POWER : ST_SEND;
            end
         end
         ST_POWER: begin
            if (status.out_free) begin
               cmd.emit_power = 1'b1;
               state_in       = ST_SEND;
            end
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.emit_phase = 1'b1;
               if (status.seq_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/lcd_nibble_interface_sequencer.sv -----
// lcd_nibble_interface_sequencer: top level joining controller and datapath
// depends on lcdnib_pkg, lcdnib_ctrl and lcdnib_dp
//
// Turns commands for a character LCD on a 4-bit bus into a stream of pin states.
// Request channel (req_): one word per command, with command, value, column and row.
// Response channel (rsp_): one word per pin state: enable, data nibble and hold
// time in tdata, register select in tuser, and tlast on the final state.
// Instruction, data, clear and goto give 5 states; init gives 36 states
// (a 15000 us power-up wait, then seven set-up bytes). Command codes 5 to 7
// are accepted and give nothing.
// After a request is accepted, the state machine enters its send (or power-up) state
// and then loads the first state into the output register, for init as for every
// other command; then one state per cycle while the receiver takes them.
// The state machine steps the command one pin state at a time through the single
// output register.
// req_tready is high only while no command is in progress; the next command may
// be taken while the final state still waits in the output register.
// A stall on rsp_tready holds the state in the output register and freezes the
// sequence. Synchronous reset drops rsp_tvalid, abandons any command and
// returns to waiting for a request.
module lcd_nibble_interface_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // command[2:0], value[10:3], column[16:11], row[17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // enable[0], data_nibble[4:1], wait_us[18:5]
   output logic        rsp_tuser,  // reg_select[0]
   output logic        rsp_tlast
);

   lcdnib_pkg::dp_cmd_type    cmd;
   lcdnib_pkg::dp_status_type status;

   logic [lcdnib_pkg::CMD_W-1:0]  req_command;
   logic [lcdnib_pkg::BYTE_W-1:0] req_value;
   logic [lcdnib_pkg::COL_W-1:0]  req_column;
   logic                          req_row;
   logic                          rsp_enable;
   logic [lcdnib_pkg::NIB_W-1:0]  rsp_nibble;
   logic [lcdnib_pkg::WAIT_W-1:0] rsp_wait_us;

   // unpack request word
   assign req_command = req_tdata[2:0];
   assign req_value   = req_tdata[10:3];
   assign req_column  = req_tdata[16:11];
   assign req_row     = req_tdata[17];

   lcdnib_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_command),
      .status     (status),
      .cmd        (cmd)
   );

   lcdnib_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_command     (req_command),
      .in_value       (req_value),
      .in_column      (req_column),
      .in_row         (req_row),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_reg_select (rsp_tuser),
      .out_enable     (rsp_enable),
      .out_nibble     (rsp_nibble),
      .out_wait_us    (rsp_wait_us),
      .out_last       (rsp_tlast)
   );

   // pack response word
   assign rsp_tdata = {5'b0, rsp_wait_us, rsp_nibble, rsp_enable};

endmodule

// ----- design/lcdnib_checker.sv -----
// lcdnib_checker: port-level assertions for the lcd nibble interface sequencer
// depends on lcdnib_pkg and the top level's ports; bound to the top level below
module lcdnib_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // a known command blocks further requests next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[2:0] <= lcdnib_pkg::CMD_GOTO) |=> !req_tready)
      else $error("request taken while command in progress");

   // hold time is the strobe time or the power-up wait, and the wait has no strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:5] == lcdnib_pkg::WAIT_STROBE)
         || (rsp_tdata[18:5] == lcdnib_pkg::WAIT_POWER_UP && !rsp_tdata[0] && !rsp_tlast))
      else $error("bad hold time in response word");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind lcd_nibble_interface_sequencer lcdnib_checker u_lcdnib_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
